### hdl/mcd_pkg.sv
// ---------------------------------------------------------------------------
// mcd_pkg: shared types and constants for the mountain car step engine
// Widths, fixed-point constants, state encodings, configuration layout and
// the CORDIC arctangent table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcd_pkg;

	// default build parameters
	localparam int CORDIC_STEPS_DEF = 20;
	localparam int FRAC_BITS_DEF    = 20;

	// field widths
	localparam int POS_W      = 24;
	localparam int VEL_W      = 22;
	localparam int GAIN_W     = 16;
	localparam int LIM_W      = 21;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// cordic datapath widths
	localparam int ANG_W      = 35;
	localparam int XY_W       = 33;
	localparam int ATAN_IDX_W = 5;

	typedef logic [ATAN_IDX_W-1:0] atan_idx_t;

	// angle constants in q30
	localparam logic signed [ANG_W-1:0] Q30_PI      = 35'sd3373259426;
	localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 35'sd1686629713;
	localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 35'sd6746518852;
	// cordic start vector, limiting gain in q30
	localparam logic signed [XY_W-1:0]  Q30_GAIN    = 33'sd652032874;

	// action codes
	typedef enum logic [1:0] {
		ACT_LEFT    = 2'd0,
		ACT_NONE    = 2'd1,
		ACT_RIGHT   = 2'd2,
		ACT_RESTART = 2'd3
	} act_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FORCE_GAIN     = 3'd0,
		CFG_GRAVITY_GAIN   = 3'd1,
		CFG_POSITION_MIN   = 3'd2,
		CFG_POSITION_MAX   = 3'd3,
		CFG_VELOCITY_LIMIT = 3'd4,
		CFG_FINISH_POS     = 3'd5,
		CFG_FINISH_VEL     = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic        [GAIN_W-1:0] force_gain;
		logic        [GAIN_W-1:0] gravity_gain;
		logic signed [POS_W-1:0]  position_min;
		logic signed [POS_W-1:0]  position_max;
		logic        [LIM_W-1:0]  velocity_limit;
		logic signed [POS_W-1:0]  finish_pos;
		logic signed [VEL_W-1:0]  finish_vel;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		force_gain:     16'd1049,
		gravity_gain:   16'd2621,
		position_min:   -24'sd1258291,
		position_max:   24'sd629146,
		velocity_limit: 21'd73400,
		finish_pos:     24'sd524288,
		finish_vel:     22'sd0
	};

	// cosine unit sequencer
	typedef enum logic [2:0] {
		COS_IDLE,
		COS_REDUCE,
		COS_WRAP,
		COS_FOLD,
		COS_ROTATE,
		COS_SIGN
	} cos_state_t;

	// step sequencer
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COS,
		ST_MUL,
		ST_GRAV,
		ST_VSUM,
		ST_VCLAMP,
		ST_PSUM,
		ST_PCLAMP,
		ST_FINISH
	} step_state_t;

	// update datapath controls
	typedef struct packed {
		logic accept;
		logic mul;
		logic grav;
		logic vsum;
		logic vclamp;
		logic psum;
		logic pclamp;
		logic commit;
	} upd_ctrl_t;

	// finished state of one step
	typedef struct packed {
		logic signed [POS_W-1:0] pos;
		logic signed [VEL_W-1:0] vel;
		logic                    done;
	} step_res_t;

	// arctangent of 2^-i in q30, truncated
	function automatic logic [30:0] atan_q30(input atan_idx_t idx);
		logic [30:0] val;
		case (idx)
			5'd0:    val = 31'd843314856;
			5'd1:    val = 31'd497837829;
			5'd2:    val = 31'd263043836;
			5'd3:    val = 31'd133525158;
			5'd4:    val = 31'd67021686;
			5'd5:    val = 31'd33543515;
			5'd6:    val = 31'd16775850;
			5'd7:    val = 31'd8388437;
			5'd8:    val = 31'd4194282;
			5'd9:    val = 31'd2097149;
			5'd10:   val = 31'd1048575;
			5'd11:   val = 31'd524287;
			5'd12:   val = 31'd262143;
			5'd13:   val = 31'd131071;
			5'd14:   val = 31'd65535;
			5'd15:   val = 31'd32767;
			5'd16:   val = 31'd16383;
			5'd17:   val = 31'd8191;
			5'd18:   val = 31'd4095;
			5'd19:   val = 31'd2047;
			5'd20:   val = 31'd1023;
			5'd21:   val = 31'd511;
			5'd22:   val = 31'd255;
			5'd23:   val = 31'd127;
			default: val = 31'd0;
		endcase
		return val;
	endfunction

endpackage

`default_nettype wire

### hdl/mcd_cfg_regs.sv
// ---------------------------------------------------------------------------
// mcd_cfg_regs: configuration register file
// Seven gain, bound and goal registers written through a plain write port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcd_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mcd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mcd_pkg::CFG_DATA_W-1:0]    cfg_data,
	output mcd_pkg::cfg_t                     cfg
);

	mcd_pkg::cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= mcd_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mcd_pkg::CFG_FORCE_GAIN:     cfg_q.force_gain     <= cfg_data[15:0];
				mcd_pkg::CFG_GRAVITY_GAIN:   cfg_q.gravity_gain   <= cfg_data[15:0];
				mcd_pkg::CFG_POSITION_MIN:   cfg_q.position_min   <= cfg_data[23:0];
				mcd_pkg::CFG_POSITION_MAX:   cfg_q.position_max   <= cfg_data[23:0];
				mcd_pkg::CFG_VELOCITY_LIMIT: cfg_q.velocity_limit <= cfg_data[20:0];
				mcd_pkg::CFG_FINISH_POS:     cfg_q.finish_pos     <= cfg_data[23:0];
				mcd_pkg::CFG_FINISH_VEL:     cfg_q.finish_vel     <= cfg_data[21:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### hdl/mcd_cos_unit.sv
// ---------------------------------------------------------------------------
// mcd_cos_unit: iterative cosine of three times the position
// Reduces the q30 angle modulo two pi by restoring subtraction, wraps and
// folds it into the right half plane, then runs one CORDIC rotation per
// cycle on a shared add/shift unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcd_cos_unit #(
	parameter int CORDIC_STEPS = mcd_pkg::CORDIC_STEPS_DEF,
	parameter int FRAC_BITS    = mcd_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [mcd_pkg::POS_W-1:0]    position,
	output logic                                done,
	output logic signed [mcd_pkg::XY_W-1:0]     cos_val
);

	localparam int AW        = mcd_pkg::ANG_W;
	localparam int XW        = mcd_pkg::XY_W;
	// left shift that takes 3*position to q30
	localparam int SHIFT     = 30 - FRAC_BITS;
	// magnitude bits of the scaled angle
	localparam int TM        = 25 + SHIFT;
	localparam int MW        = (TM > 33) ? TM : 33;
	localparam int MOD_STEPS = (SHIFT > 8) ? (SHIFT - 7) : 1;
	localparam int LOOP_MAX  = (CORDIC_STEPS > MOD_STEPS) ? CORDIC_STEPS : MOD_STEPS;
	localparam int CNT_W     = $clog2(LOOP_MAX);
	localparam logic [MW-1:0] D_TOP = MW'(mcd_pkg::Q30_TWO_PI) << (MOD_STEPS - 1);

	mcd_pkg::cos_state_t state_q, state_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;

	logic [MW-1:0]        r_q, d_q;
	logic                 sgn_q, neg_q;
	logic signed [AW-1:0] z_q;
	logic signed [XW-1:0] x_q, y_q, cos_q;

	logic signed [25:0]   p3;
	logic [24:0]          mag;
	logic signed [AW-1:0] r_s, wrap_v, at_s;
	logic                 r_gt_pi;
	logic signed [XW-1:0] dx, dy;

	// state and loop counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcd_pkg::COS_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		cnt_d   = '0;
		case (state_q)
			mcd_pkg::COS_IDLE: begin
				if (start) state_d = mcd_pkg::COS_REDUCE;
			end
			mcd_pkg::COS_REDUCE: begin
				if (cnt_q == CNT_W'(MOD_STEPS - 1)) begin
					state_d = mcd_pkg::COS_WRAP;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			mcd_pkg::COS_WRAP:  state_d = mcd_pkg::COS_FOLD;
			mcd_pkg::COS_FOLD:  state_d = mcd_pkg::COS_ROTATE;
			mcd_pkg::COS_ROTATE: begin
				if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
					state_d = mcd_pkg::COS_SIGN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			mcd_pkg::COS_SIGN: state_d = mcd_pkg::COS_IDLE;
			default:           state_d = mcd_pkg::COS_IDLE;
		endcase
	end

	// magnitude of 3*position before scaling
	assign p3  = 26'(position) + (26'(position) <<< 1);
	assign mag = p3[25] ? 25'(-p3) : 25'(p3);

	// wrap the remainder into [-pi, pi] with the angle's sign
	assign r_s     = $signed({2'b00, r_q[32:0]});
	assign r_gt_pi = r_s > mcd_pkg::Q30_PI;
	always_comb begin
		if (sgn_q) begin
			wrap_v = r_gt_pi ? (mcd_pkg::Q30_TWO_PI - r_s) : -r_s;
		end else begin
			wrap_v = r_gt_pi ? (r_s - mcd_pkg::Q30_TWO_PI) : r_s;
		end
	end

	// rotation operands
	assign dx   = x_q >>> cnt_q;
	assign dy   = y_q >>> cnt_q;
	assign at_s = $signed(AW'(mcd_pkg::atan_q30(mcd_pkg::atan_idx_t'(cnt_q))));

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			mcd_pkg::COS_IDLE: begin
				if (start) begin
					r_q   <= MW'(mag) << SHIFT;
					d_q   <= D_TOP;
					sgn_q <= p3[25];
				end
			end
			mcd_pkg::COS_REDUCE: begin
				if (r_q >= d_q) r_q <= r_q - d_q;
				d_q <= d_q >> 1;
			end
			mcd_pkg::COS_WRAP: begin
				z_q <= wrap_v;
				x_q <= mcd_pkg::Q30_GAIN;
				y_q <= '0;
			end
			mcd_pkg::COS_FOLD: begin
				if (z_q > mcd_pkg::Q30_HALF_PI) begin
					z_q   <= z_q - mcd_pkg::Q30_PI;
					neg_q <= 1'b1;
				end else if (z_q < -mcd_pkg::Q30_HALF_PI) begin
					z_q   <= z_q + mcd_pkg::Q30_PI;
					neg_q <= 1'b1;
				end else begin
					neg_q <= 1'b0;
				end
			end
			mcd_pkg::COS_ROTATE: begin
				if (!z_q[AW-1]) begin
					x_q <= x_q - dy;
					y_q <= y_q + dx;
					z_q <= z_q - at_s;
				end else begin
					x_q <= x_q + dy;
					y_q <= y_q - dx;
					z_q <= z_q + at_s;
				end
			end
			mcd_pkg::COS_SIGN: begin
				cos_q <= neg_q ? -x_q : x_q;
			end
			default: ;
		endcase
	end

	assign done    = (state_q == mcd_pkg::COS_SIGN);
	assign cos_val = cos_q;

endmodule

`default_nettype wire

### hdl/mcd_update.sv
// ---------------------------------------------------------------------------
// mcd_update: velocity and position update datapath
// Holds the car state and, one operation per cycle, applies gravity, push,
// velocity clamp, position move and clamp, wall stop and the goal test.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcd_update (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mcd_pkg::upd_ctrl_t                 ctrl,
	input  logic [1:0]                         action,
	input  logic signed [mcd_pkg::POS_W-1:0]   start_position,
	input  mcd_pkg::cfg_t                      cfg,
	input  logic signed [mcd_pkg::XY_W-1:0]    cos_val,
	output logic signed [mcd_pkg::POS_W-1:0]   position,
	output mcd_pkg::step_res_t                 res
);

	localparam int PW  = mcd_pkg::POS_W;
	localparam int VW  = mcd_pkg::VEL_W;
	localparam int SW  = VW + 2;
	localparam int PSW = PW + 1;
	localparam int PRW = mcd_pkg::GAIN_W + 1 + mcd_pkg::XY_W;
	localparam int GW  = PRW - 30;
	localparam logic signed [PRW-1:0] ROUND_HALF = PRW'(64'sd536870912);

	logic [1:0]            act_q;
	logic signed [PRW-1:0] prod_q, prod_rnd;
	logic signed [GW-1:0]  grav_q;
	logic signed [SW-1:0]  vsum_q, fterm, lim_s, vclamp;
	logic signed [VW-1:0]  vel_new_q, vel_fin, velocity_q;
	logic signed [PSW-1:0] psum_q, pmin_e, pmax_e, plow, phigh;
	logic signed [PW-1:0]  pos_new_q, position_q;
	logic signed [16:0]    force_s;
	logic                  wall;

	// push term from the action
	assign force_s = $signed({1'b0, cfg.force_gain});
	always_comb begin
		case (act_q)
			mcd_pkg::ACT_LEFT:  fterm = -SW'(force_s);
			mcd_pkg::ACT_RIGHT: fterm = SW'(force_s);
			default:            fterm = '0;
		endcase
	end

	// gravity rounding, half up then floor
	assign prod_rnd = prod_q + ROUND_HALF;

	// velocity clamp
	assign lim_s = SW'($signed({1'b0, cfg.velocity_limit}));
	always_comb begin
		vclamp = vsum_q;
		if (vsum_q < -lim_s) vclamp = -lim_s;
		if (vsum_q > lim_s)  vclamp = lim_s;
	end

	// position clamp, lower bound first
	assign pmin_e = PSW'($signed(cfg.position_min));
	assign pmax_e = PSW'($signed(cfg.position_max));
	assign plow   = (psum_q < pmin_e) ? pmin_e : psum_q;
	assign phigh  = (plow > pmax_e) ? pmax_e : plow;

	// wall stop and goal test on the new state
	assign wall    = (pos_new_q == $signed(cfg.position_min)) && vel_new_q[VW-1];
	assign vel_fin = wall ? '0 : vel_new_q;

	// working registers
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			act_q <= action;
			if (action == mcd_pkg::ACT_RESTART) begin
				pos_new_q <= start_position;
				vel_new_q <= '0;
			end
		end
		if (ctrl.mul)    prod_q    <= $signed({1'b0, cfg.gravity_gain}) * cos_val;
		if (ctrl.grav)   grav_q    <= prod_rnd[PRW-1:30];
		if (ctrl.vsum)   vsum_q    <= SW'(velocity_q) + fterm - SW'(grav_q);
		if (ctrl.vclamp) vel_new_q <= VW'(vclamp);
		if (ctrl.psum)   psum_q    <= PSW'(position_q) + PSW'(vel_new_q);
		if (ctrl.pclamp) pos_new_q <= PW'(phigh);
	end

	// car state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			velocity_q <= '0;
		end else if (ctrl.commit) begin
			position_q <= pos_new_q;
			velocity_q <= vel_fin;
		end
	end

	assign position = position_q;
	assign res.pos  = pos_new_q;
	assign res.vel  = vel_fin;
	assign res.done = (pos_new_q >= $signed(cfg.finish_pos)) &&
	                  (vel_fin >= $signed(cfg.finish_vel));

endmodule

`default_nettype wire

### hdl/mountain_car_dynamics_step.sv
// ---------------------------------------------------------------------------
// mountain_car_dynamics_step: fixed-point mountain car environment step
// Keeps the car position (Q4.20, 24 bits) and velocity (22 bits) and, for
// each accepted beat, applies a push left, no push, push right or a restart
// to a given start position, returning the new state, reward and done flag.
// A push beat runs the cosine unit, which reduces the angle one restoring
// subtract per cycle and then runs one CORDIC rotation per cycle, followed
// by one multiply, add or clamp per cycle in the update datapath; a restart
// beat goes straight to the result. step_stall is high for the whole step; a
// finished result sits in an output register until taken, and the next step
// beat is accepted meanwhile. Configuration registers may be written only
// while the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mountain_car_dynamics_step #(
	parameter int CORDIC_STEPS = mcd_pkg::CORDIC_STEPS_DEF,
	parameter int FRAC_BITS    = mcd_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [mcd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mcd_pkg::CFG_DATA_W-1:0]     cfg_data,
	// step channel
	input  logic                               step_valid,
	output logic                               step_stall,
	input  logic [1:0]                         action,
	input  logic signed [mcd_pkg::POS_W-1:0]   start_position,
	// result channel
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic signed [mcd_pkg::POS_W-1:0]   car_position,
	output logic signed [mcd_pkg::VEL_W-1:0]   car_velocity,
	output logic signed                        reward,
	output logic                               done_res
);

	mcd_pkg::step_state_t state_q, state_d;
	mcd_pkg::upd_ctrl_t   ctrl;
	mcd_pkg::cfg_t        cfg;
	mcd_pkg::step_res_t   res;

	logic                                cos_start, cos_done, commit, out_free;
	logic signed [mcd_pkg::XY_W-1:0]     cos_val;
	logic signed [mcd_pkg::POS_W-1:0]    position;

	logic                                result_valid_q;
	logic signed [mcd_pkg::POS_W-1:0]    car_position_q;
	logic signed [mcd_pkg::VEL_W-1:0]    car_velocity_q;
	logic                                reward_q, done_res_q;

	mcd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mcd_cos_unit #(
		.CORDIC_STEPS (CORDIC_STEPS),
		.FRAC_BITS    (FRAC_BITS)
	) u_cos (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cos_start),
		.position (position),
		.done     (cos_done),
		.cos_val  (cos_val)
	);

	mcd_update u_upd (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.action         (action),
		.start_position (start_position),
		.cfg            (cfg),
		.cos_val        (cos_val),
		.position       (position),
		.res            (res)
	);

	// output register is free when empty or being drained
	assign out_free = !result_valid_q || !result_stall;

	// step sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath controls
	always_comb begin
		state_d   = state_q;
		ctrl      = '0;
		cos_start = 1'b0;
		commit    = 1'b0;
		case (state_q)
			mcd_pkg::ST_IDLE: begin
				if (step_valid) begin
					ctrl.accept = 1'b1;
					if (action == mcd_pkg::ACT_RESTART) begin
						state_d = mcd_pkg::ST_FINISH;
					end else begin
						cos_start = 1'b1;
						state_d   = mcd_pkg::ST_COS;
					end
				end
			end
			mcd_pkg::ST_COS: begin
				if (cos_done) state_d = mcd_pkg::ST_MUL;
			end
			mcd_pkg::ST_MUL: begin
				ctrl.mul = 1'b1;
				state_d  = mcd_pkg::ST_GRAV;
			end
			mcd_pkg::ST_GRAV: begin
				ctrl.grav = 1'b1;
				state_d   = mcd_pkg::ST_VSUM;
			end
			mcd_pkg::ST_VSUM: begin
				ctrl.vsum = 1'b1;
				state_d   = mcd_pkg::ST_VCLAMP;
			end
			mcd_pkg::ST_VCLAMP: begin
				ctrl.vclamp = 1'b1;
				state_d     = mcd_pkg::ST_PSUM;
			end
			mcd_pkg::ST_PSUM: begin
				ctrl.psum = 1'b1;
				state_d   = mcd_pkg::ST_PCLAMP;
			end
			mcd_pkg::ST_PCLAMP: begin
				ctrl.pclamp = 1'b1;
				state_d     = mcd_pkg::ST_FINISH;
			end
			mcd_pkg::ST_FINISH: begin
				if (out_free) begin
					commit      = 1'b1;
					ctrl.commit = 1'b1;
					state_d     = mcd_pkg::ST_IDLE;
				end
			end
			default: state_d = mcd_pkg::ST_IDLE;
		endcase
	end

	assign step_stall = (state_q != mcd_pkg::ST_IDLE);

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (commit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (commit) begin
			car_position_q <= res.pos;
			car_velocity_q <= res.vel;
			reward_q       <= ~res.done;
			done_res_q     <= res.done;
		end
	end

	assign result_valid = result_valid_q;
	assign car_position = car_position_q;
	assign car_velocity = car_velocity_q;
	assign reward       = reward_q;
	assign done_res     = done_res_q;

endmodule

`default_nettype wire

### hdl/mcd_checker.sv
// ---------------------------------------------------------------------------
// mcd_checker: port-level checks for the mountain car step engine
// Watches the step and result channels and is bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcd_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               step_valid,
	input logic                               step_stall,
	input logic                               result_valid,
	input logic                               result_stall,
	input logic signed [mcd_pkg::POS_W-1:0]   car_position,
	input logic signed [mcd_pkg::VEL_W-1:0]   car_velocity,
	input logic signed                        reward,
	input logic                               done_res
);

	// a taken step beat keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid && !step_stall |=> step_stall)
		else $error("step beat accepted while block not busy afterwards");

	// a new result only shows up after the block was working
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(step_stall))
		else $error("result beat appeared without a step in progress");

	// reward and done flag always disagree
	a_reward_matches_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (reward != done_res))
		else $error("reward inconsistent with done flag");

	// stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(car_position) &&
			$stable(car_velocity) && $stable(done_res))
		else $error("stalled result beat changed");

endmodule

bind mountain_car_dynamics_step mcd_checker u_mcd_checker (.*);

`default_nettype wire

### dv/mountain_car_dynamics_step_test.sv
// ----------------------------------------------------------------------------
// mountain_car_dynamics_step_test: self-checking bench for the car step engine
// Sends push and restart beats under several register settings. An integer
// copy of the car dynamics, including the CORDIC cosine, predicts every
// result beat, and each result beat is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mountain_car_dynamics_step_test;

	localparam int STEPS       = mcd_pkg::CORDIC_STEPS_DEF;
	localparam int FRAC        = mcd_pkg::FRAC_BITS_DEF;
	localparam int CLK_PERIOD  = 10;
	localparam int RESET_CYCLES = 7;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 3000;
	localparam int TAIL_CYCLES = 60;

	// register index with no register behind it
	localparam logic [mcd_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

	localparam logic signed [mcd_pkg::POS_W-1:0] POS_FLOOR = 24'sh800000;
	localparam logic signed [mcd_pkg::POS_W-1:0] POS_CEIL  = 24'sh7FFFFF;

	localparam longint PI_Q30      = mcd_pkg::Q30_PI;
	localparam longint HALF_PI_Q30 = mcd_pkg::Q30_HALF_PI;
	localparam longint TWO_PI_Q30  = mcd_pkg::Q30_TWO_PI;
	localparam longint GAIN_Q30    = mcd_pkg::Q30_GAIN;

	typedef enum {
		STYLE_RANDOM,
		STYLE_PUMP,
		STYLE_HOLD
	} drive_style_t;

	typedef struct {
		longint pos;
		longint vel;
		logic   done;
	} car_outcome_t;

	// predicted car state, register copy and queue of outcomes still due
	class car_scoreboard;
		longint force_gain, gravity_gain, pos_lo, pos_hi, vel_limit, goal_pos, goal_vel;
		longint pos, vel;
		longint atan_steps[24];
		car_outcome_t outcomes_due[$];
		int errors, restarts, pushes, goals, wall_stops, top_pins, speed_caps;

		function new();
			atan_steps = '{
				843314856, 497837829, 263043836, 133525158,
				67021686, 33543515, 16775850, 8388437,
				4194282, 2097149, 1048575, 524287,
				262143, 131071, 65535, 32767,
				16383, 8191, 4095, 2047,
				1023, 511, 255, 127
			};
			pos = 0;
			vel = 0;
			force_gain = mcd_pkg::CFG_RESET.force_gain;
			gravity_gain = mcd_pkg::CFG_RESET.gravity_gain;
			pos_lo = $signed(mcd_pkg::CFG_RESET.position_min);
			pos_hi = $signed(mcd_pkg::CFG_RESET.position_max);
			vel_limit = mcd_pkg::CFG_RESET.velocity_limit;
			goal_pos = $signed(mcd_pkg::CFG_RESET.finish_pos);
			goal_vel = $signed(mcd_pkg::CFG_RESET.finish_vel);
		endfunction

		function void write_reg(logic [mcd_pkg::CFG_IDX_W-1:0] idx,
				logic [mcd_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				mcd_pkg::CFG_FORCE_GAIN:     force_gain = data[mcd_pkg::GAIN_W-1:0];
				mcd_pkg::CFG_GRAVITY_GAIN:   gravity_gain = data[mcd_pkg::GAIN_W-1:0];
				mcd_pkg::CFG_POSITION_MIN:   pos_lo = $signed(data[mcd_pkg::POS_W-1:0]);
				mcd_pkg::CFG_POSITION_MAX:   pos_hi = $signed(data[mcd_pkg::POS_W-1:0]);
				mcd_pkg::CFG_VELOCITY_LIMIT: vel_limit = data[mcd_pkg::LIM_W-1:0];
				mcd_pkg::CFG_FINISH_POS:     goal_pos = $signed(data[mcd_pkg::POS_W-1:0]);
				mcd_pkg::CFG_FINISH_VEL:     goal_vel = $signed(data[mcd_pkg::VEL_W-1:0]);
				default: ;
			endcase
		endfunction

		// cos(3 * position) in q30: reduce, fold to +/- pi/2, rotate
		function longint cosine_q30(longint p);
			longint t, x, y, dx, dy;
			bit flip;
			t = (p * 3 * (longint'(1) << (30 - FRAC))) % TWO_PI_Q30;
			x = GAIN_Q30;
			y = 0;
			flip = 1'b0;
			if (t > PI_Q30) t -= TWO_PI_Q30;
			if (t < -PI_Q30) t += TWO_PI_Q30;
			if (t > HALF_PI_Q30) begin
				t -= PI_Q30;
				flip = 1'b1;
			end else if (t < -HALF_PI_Q30) begin
				t += PI_Q30;
				flip = 1'b1;
			end
			for (int i = 0; i < STEPS && i < 24; i++) begin
				dx = x >>> i;
				dy = y >>> i;
				if (t >= 0) begin
					x -= dy;
					y += dx;
					t -= atan_steps[i];
				end else begin
					x += dy;
					y -= dx;
					t += atan_steps[i];
				end
			end
			return flip ? -x : x;
		endfunction

		// advance the car by one accepted step beat
		function void note_step(mcd_pkg::act_t act, logic signed [mcd_pkg::POS_W-1:0] start);
			longint g;
			car_outcome_t o;
			if (act == mcd_pkg::ACT_RESTART) begin
				o.pos = start;
				o.vel = 0;
				restarts++;
			end else begin
				g = (gravity_gain * cosine_q30(pos) + (longint'(1) << 29)) >>> 30;
				o.vel = vel + (longint'(act) - 1) * force_gain - g;
				if (o.vel < -vel_limit || o.vel > vel_limit) speed_caps++;
				if (o.vel < -vel_limit) o.vel = -vel_limit;
				if (o.vel > vel_limit) o.vel = vel_limit;
				o.pos = pos + o.vel;
				if (o.pos < pos_lo) o.pos = pos_lo;
				if (o.pos > pos_hi) begin
					o.pos = pos_hi;
					top_pins++;
				end
				// car parked against the lower wall
				if (o.pos == pos_lo && o.vel < 0) begin
					o.vel = 0;
					wall_stops++;
				end
				pushes++;
			end
			o.done = (o.pos >= goal_pos) && (o.vel >= goal_vel);
			if (o.done) goals++;
			pos = o.pos;
			vel = o.vel;
			outcomes_due.insert(outcomes_due.size(), o);
		endfunction

		function void compare_field(string field, logic signed [31:0] want,
				logic signed [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic signed [mcd_pkg::POS_W-1:0] p,
				logic signed [mcd_pkg::VEL_W-1:0] v, logic r, logic d);
			car_outcome_t o;
			if (outcomes_due.size() == 0) begin
				$error("result beat at position %0d with no step outstanding", p);
				errors++;
				return;
			end
			o = outcomes_due.pop_front();
			compare_field("car_position", o.pos, p);
			compare_field("car_velocity", o.vel, v);
			compare_field("reward", !o.done, r);
			compare_field("done_res", o.done, d);
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [mcd_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
	logic [mcd_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
	logic                             step_valid = 1'b0;
	logic                             step_stall;
	logic [1:0]                       action = mcd_pkg::ACT_NONE;
	logic signed [mcd_pkg::POS_W-1:0] start_position = '0;
	logic                             result_valid;
	logic                             result_stall = 1'b0;
	logic signed [mcd_pkg::POS_W-1:0] car_position;
	logic signed [mcd_pkg::VEL_W-1:0] car_velocity;
	logic signed                      reward;
	logic                             done_res;

	car_scoreboard sb;
	bit hold_req = 1'b0;
	bit quiet_all = 1'b0;
	bit tx_calm = 1'b0;
	int setting_count = 1;

	mountain_car_dynamics_step #(
		.CORDIC_STEPS(STEPS),
		.FRAC_BITS(FRAC)
	) i_dut (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// every accepted result beat against the oldest outcome due
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(car_position, car_velocity, reward, done_res);
	end

	// result side: stall bursts, calm stretches and one long hold-off
	initial begin : result_sink
		int stall_left;
		int calm_left;
		bit rx_calm;
		stall_left = 0;
		calm_left = 0;
		rx_calm = 1'b0;
		forever begin
			@(negedge clk);
			if (calm_left == 0) begin
				rx_calm = ($urandom_range(0, 3) == 0);
				calm_left = 150;
			end
			calm_left--;
			if (stall_left == 0) begin
				if (hold_req) begin
					stall_left = HOLD_CYCLES;
					hold_req = 1'b0;
				end else if (!quiet_all && !rx_calm && $urandom_range(0, 4) == 0) begin
					stall_left = $urandom_range(1, 5);
				end
			end
			result_stall <= (stall_left != 0);
			if (stall_left != 0) stall_left--;
		end
	end

	// ends the run when no beat moves on either channel for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((step_valid && !step_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$error("no beat moved for %0d cycles", STALL_LIMIT);
		$display("mountain_car_dynamics_step test failed");
		$finish;
	end

	// one step beat, with an optional gap in front of it
	task automatic send_step(input mcd_pkg::act_t act,
			input logic signed [mcd_pkg::POS_W-1:0] start);
		if (!quiet_all && !tx_calm && $urandom_range(0, 5) == 0) begin
			step_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		step_valid     <= 1'b1;
		action         <= act;
		start_position <= start;
		do @(posedge clk); while (step_stall);
		sb.note_step(act, start);
		@(negedge clk);
	endtask

	// hold the step side until every outcome due has come back
	task automatic drain();
		step_valid <= 1'b0;
		while (sb.outcomes_due.size() != 0) @(negedge clk);
	endtask

	task automatic poke(input logic [mcd_pkg::CFG_IDX_W-1:0] idx,
			input logic [mcd_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
		@(negedge clk);
	endtask

	// write all registers once the block is idle; spare bits carry noise
	task automatic load_setting(input mcd_pkg::cfg_t c);
		drain();
		poke(mcd_pkg::CFG_FORCE_GAIN, {8'($urandom), c.force_gain});
		poke(mcd_pkg::CFG_GRAVITY_GAIN, {8'($urandom), c.gravity_gain});
		poke(mcd_pkg::CFG_POSITION_MIN, c.position_min);
		poke(mcd_pkg::CFG_POSITION_MAX, c.position_max);
		poke(mcd_pkg::CFG_VELOCITY_LIMIT, {3'($urandom), c.velocity_limit});
		poke(mcd_pkg::CFG_FINISH_POS, c.finish_pos);
		poke(mcd_pkg::CFG_FINISH_VEL, {2'($urandom), c.finish_vel});
		poke(CFG_SPARE_IDX, mcd_pkg::CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
		setting_count++;
	endtask

	function automatic mcd_pkg::cfg_t random_setting();
		mcd_pkg::cfg_t c;
		logic signed [mcd_pkg::POS_W-1:0] a, b;
		a = mcd_pkg::POS_W'($urandom);
		b = mcd_pkg::POS_W'($urandom);
		// mostly ordered bounds, now and then crossed ones
		if (a > b && $urandom_range(0, 4) != 0) begin
			c.position_min = b;
			c.position_max = a;
		end else begin
			c.position_min = a;
			c.position_max = b;
		end
		c.force_gain = ($urandom_range(0, 3) == 0) ? mcd_pkg::GAIN_W'($urandom)
			: mcd_pkg::GAIN_W'($urandom_range(0, 4000));
		c.gravity_gain = ($urandom_range(0, 3) == 0) ? mcd_pkg::GAIN_W'($urandom)
			: mcd_pkg::GAIN_W'($urandom_range(0, 6000));
		c.velocity_limit = mcd_pkg::LIM_W'($urandom_range(0, 1048576));
		if (c.position_min <= c.position_max)
			c.finish_pos = mcd_pkg::POS_W'(longint'(c.position_min)
				+ $urandom_range(0, 32'(longint'(c.position_max) - c.position_min)));
		else
			c.finish_pos = mcd_pkg::POS_W'($urandom);
		c.finish_vel = mcd_pkg::VEL_W'(int'($urandom_range(0, 2097152)) - 1048576);
		return c;
	endfunction

	// episodes: a restart, then a run of pushes in one driving style
	task automatic run_episodes(input int n);
		int sent;
		int len;
		drive_style_t style;
		mcd_pkg::act_t held;
		mcd_pkg::act_t act;
		logic signed [mcd_pkg::POS_W-1:0] start;
		sent = 0;
		while (sent < n) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			if (sb.pos_lo <= sb.pos_hi && $urandom_range(0, 9) != 0)
				start = mcd_pkg::POS_W'(sb.pos_lo
					+ $urandom_range(0, 32'(sb.pos_hi - sb.pos_lo)));
			else
				start = mcd_pkg::POS_W'($urandom);
			send_step(mcd_pkg::ACT_RESTART, start);
			sent++;
			len = $urandom_range(5, 150);
			style = drive_style_t'($urandom_range(0, 2));
			held = ($urandom_range(0, 1) == 0) ? mcd_pkg::ACT_LEFT : mcd_pkg::ACT_RIGHT;
			for (int k = 0; k < len && sent < n; k++) begin
				case (style)
					STYLE_PUMP: act = (sb.vel >= 0) ? mcd_pkg::ACT_RIGHT : mcd_pkg::ACT_LEFT;
					STYLE_HOLD: act = held;
					default:    act = mcd_pkg::act_t'($urandom_range(0, 2));
				endcase
				// occasional off-pattern push or broken-off episode
				if ($urandom_range(0, 9) == 0) act = mcd_pkg::act_t'($urandom_range(0, 2));
				if ($urandom_range(0, 39) == 0) act = mcd_pkg::ACT_RESTART;
				send_step(act, mcd_pkg::POS_W'($urandom));
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		sb = new();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: every push from reset, start position extremes, walls, goal
		send_step(mcd_pkg::ACT_NONE, mcd_pkg::POS_W'($urandom));
		send_step(mcd_pkg::ACT_LEFT, mcd_pkg::POS_W'($urandom));
		send_step(mcd_pkg::ACT_RIGHT, mcd_pkg::POS_W'($urandom));
		send_step(mcd_pkg::ACT_RESTART, POS_FLOOR);
		send_step(mcd_pkg::ACT_RIGHT, mcd_pkg::POS_W'($urandom));
		send_step(mcd_pkg::ACT_RESTART, POS_CEIL);
		send_step(mcd_pkg::ACT_LEFT, mcd_pkg::POS_W'($urandom));
		send_step(mcd_pkg::ACT_RESTART, mcd_pkg::CFG_RESET.finish_pos);
		send_step(mcd_pkg::ACT_RESTART, mcd_pkg::CFG_RESET.finish_pos - 1);
		send_step(mcd_pkg::ACT_RESTART, mcd_pkg::CFG_RESET.position_min);
		send_step(mcd_pkg::ACT_LEFT, mcd_pkg::POS_W'($urandom));
		send_step(mcd_pkg::ACT_LEFT, mcd_pkg::POS_W'($urandom));
		send_step(mcd_pkg::ACT_RESTART, mcd_pkg::CFG_RESET.position_min - 1);
		send_step(mcd_pkg::ACT_NONE, mcd_pkg::POS_W'($urandom));
		send_step(mcd_pkg::ACT_RESTART, mcd_pkg::CFG_RESET.position_max);
		repeat (3) send_step(mcd_pkg::ACT_RIGHT, mcd_pkg::POS_W'($urandom));
		send_step(mcd_pkg::ACT_RESTART, '0);
		send_step(mcd_pkg::ACT_NONE, mcd_pkg::POS_W'($urandom));
		run_episodes(200);

		// largest gains, full-range bounds and goal at the ceiling
		load_setting('{force_gain: 16'hFFFF, gravity_gain: 16'hFFFF,
			position_min: POS_FLOOR, position_max: POS_CEIL,
			velocity_limit: 21'd1048576, finish_pos: POS_CEIL,
			finish_vel: 22'sd1048576});
		run_episodes(120);

		// no force, no gravity, no speed allowed, goal always met
		load_setting('{force_gain: 16'd0, gravity_gain: 16'd0,
			position_min: mcd_pkg::CFG_RESET.position_min,
			position_max: mcd_pkg::CFG_RESET.position_max,
			velocity_limit: 21'd0, finish_pos: POS_FLOOR,
			finish_vel: -22'sd1048576});
		run_episodes(60);

		// crossed bounds: the upper clamp wins
		load_setting('{force_gain: 16'd3000, gravity_gain: 16'd2621,
			position_min: 24'sd300000, position_max: -24'sd300000,
			velocity_limit: 21'd73400, finish_pos: 24'sd0,
			finish_vel: 22'sd0});
		run_episodes(80);

		repeat (3) begin
			load_setting(random_setting());
			run_episodes(150);
		end

		// back to reset values; long result hold-off while steps keep coming
		load_setting(mcd_pkg::CFG_RESET);
		send_step(mcd_pkg::ACT_RESTART, '0);
		tx_calm = 1'b1;
		hold_req = 1'b1;
		repeat (40) send_step((sb.vel >= 0) ? mcd_pkg::ACT_RIGHT : mcd_pkg::ACT_LEFT,
			mcd_pkg::POS_W'($urandom));
		drain();
		run_episodes(60);
		drain();

		// closing stretch with no idling on either side
		quiet_all = 1'b1;
		run_episodes(150);

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("ran %0d restarts and %0d pushes under %0d register settings",
			sb.restarts, sb.pushes, setting_count);
		$display("goal reached %0d times, lower wall %0d, upper bound %0d, speed limit %0d",
			sb.goals, sb.wall_stops, sb.top_pins, sb.speed_caps);
		if (sb.errors == 0 && sb.outcomes_due.size() == 0)
			$display("mountain_car_dynamics_step test passed");
		else
			$display("mountain_car_dynamics_step test failed");
		$finish;
	end

endmodule
